### design/multichannel_dc_blocking_filter_core_macros.svh
// Assertion macros used by the DC blocking filter RTL.
`ifndef MULTICHANNEL_DC_BLOCKING_FILTER_CORE_MACROS_SVH
`define MULTICHANNEL_DC_BLOCKING_FILTER_CORE_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define MDCBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define MDCBF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### design/mdcbf_pkg.sv
// Types and constants of the multichannel DC blocking filter.
package mdcbf_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int CH_IDX_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int COEF_REGS  = 4;

  typedef enum logic [1:0] {
    FMT_16 = 2'd0,
    FMT_24 = 2'd1,
    FMT_32 = 2'd2
  } sample_fmt_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORMAT = 3'd0,
    REG_COEF01 = 3'd1,
    REG_COEF23 = 3'd2,
    REG_COEF45 = 3'd3,
    REG_COEF67 = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [CH_IDX_W-1:0]        channel;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       last_frame;
  } in_word_t;

  typedef struct packed {
    logic [CH_IDX_W-1:0]        channel_out;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_out;
  } out_word_t;

endpackage

### design/mdcbf_stream_if.sv
// Valid/ready stream interface carrying one word of a given type.
interface mdcbf_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/mdcbf_filter.sv
// Single-pass datapath: input alignment, IIR update, rounding and output narrowing.
module mdcbf_filter
  import mdcbf_pkg::*;
(
  input  logic [1:0]                 fmt_i,
  input  logic signed [SAMPLE_W-1:0] coef_i,
  input  logic signed [SAMPLE_W-1:0] x_prev_i,
  input  logic signed [SAMPLE_W-1:0] y_prev_i,
  input  logic signed [SAMPLE_W-1:0] raw_i,
  output logic signed [SAMPLE_W-1:0] x_o,
  output logic signed [SAMPLE_W-1:0] y_o,
  output logic signed [SAMPLE_W-1:0] sample_o
);

  logic signed [63:0] prod;
  logic signed [63:0] prod2;
  logic signed [32:0] diff;
  logic signed [63:0] diff_sh;
  logic signed [64:0] acc;
  logic signed [63:0] acc_dbl;
  logic signed [64:0] rnd;
  logic signed [32:0] rnd_q;
  logic signed [32:0] o16;
  logic signed [16:0] q16;
  logic signed [15:0] s16;
  logic signed [32:0] o24;
  logic signed [24:0] q24;
  logic signed [23:0] s24;

  // input placement per sample format
  always_comb begin
    case (fmt_i)
      FMT_16:  x_o = {raw_i[15:0], 16'h0000};
      FMT_24:  x_o = {raw_i[23:0], 8'h00};
      default: x_o = raw_i;
    endcase
  end

  assign prod = 64'(coef_i) * 64'(y_prev_i);

  // doubled product; only R = y_prev = -1 overflows
  assign prod2 = (prod == 64'sh4000_0000_0000_0000) ? 64'sh7FFF_FFFF_FFFF_FFFF
                                                     : {prod[62:0], 1'b0};

  assign diff    = {x_o[31], x_o} - {x_prev_i[31], x_prev_i};
  assign diff_sh = {diff, 31'b0};
  assign acc     = {diff_sh[63], diff_sh} + {prod2[63], prod2};

  // saturating add then saturating double collapse into one clamp of 2*acc
  always_comb begin
    if (acc[64:62] == 3'b000 || acc[64:62] == 3'b111) begin
      acc_dbl = {acc[62:0], 1'b0};
    end else if (acc[64]) begin
      acc_dbl = 64'sh8000_0000_0000_0000;
    end else begin
      acc_dbl = 64'sh7FFF_FFFF_FFFF_FFFF;
    end
  end

  // half away from zero: negative values add one less before the floor
  assign rnd   = {acc_dbl[63], acc_dbl}
               + (acc_dbl[63] ? 65'sh0_7FFF_FFFF : 65'sh0_8000_0000);
  assign rnd_q = rnd[64:32];
  assign y_o   = (rnd_q[32:31] == 2'b01) ? 32'sh7FFF_FFFF : rnd_q[31:0];

  assign o16 = {y_o[31], y_o} + (y_o[31] ? 33'sh0_7FFF : 33'sh0_8000);
  assign q16 = o16[32:16];
  assign s16 = (q16[16:15] == 2'b01) ? 16'sh7FFF : q16[15:0];

  // 24-bit path rounds half up
  assign o24 = {y_o[31], y_o} + 33'sd128;
  assign q24 = o24[32:8];
  always_comb begin
    if (q24[24:23] == 2'b01) begin
      s24 = 24'sh7F_FFFF;
    end else if (q24[24:23] == 2'b10) begin
      s24 = 24'sh80_0000;
    end else begin
      s24 = q24[23:0];
    end
  end

  always_comb begin
    case (fmt_i)
      FMT_16:  sample_o = {{16{s16[15]}}, s16};
      FMT_24:  sample_o = {{8{s24[23]}}, s24};
      default: sample_o = y_o;
    endcase
  end

endmodule

### design/multichannel_dc_blocking_filter_core.sv
// Top level of the multichannel DC blocking filter core.
//
//  port    | dir | word        | handshake
//  --------+-----+-------------+------------------------------
//  in_i    | in  | in_word_t   | valid/ready, sink
//  out_o   | out | out_word_t  | valid/ready, source
//  cfg_*   | in  | index, data | write enable only, no stall
//
// One word per cycle sustained while out_o is ready; two register stages (input
// register, then result register): an accepted word loads the input register,
// then the result register, which drives out_o.valid and out_o.data.
// Per-channel state is read from the input register and written as the result
// register loads, so words of the same channel may follow back to back.
// Reset clears the valid flags and channel history, sets the format register to 32-bit and clears all coefficients.
// A stalled output holds the result register; the input register still takes
// a word while the result register waits, and back-pressure reaches in_i only
// once both are full.
`include "multichannel_dc_blocking_filter_core_macros.svh"

module multichannel_dc_blocking_filter_core
  import mdcbf_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mdcbf_stream_if.sink          in_i,
  mdcbf_stream_if.source        out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int ST_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_IDX_W:0] NUM_CH = (CH_IDX_W+1)'(CHANNELS);

  // configuration
  logic [1:0]            fmt_q;
  logic [CFG_DATA_W-1:0] coef_q [COEF_REGS];

  // pipeline
  logic      s1_valid_q;
  in_word_t  s1_q;
  logic      out_valid_q;
  out_word_t out_q;
  logic      advance;

  // per-channel history
  logic signed [SAMPLE_W-1:0] prev_in_q  [CHANNELS];
  logic signed [SAMPLE_W-1:0] prev_out_q [CHANNELS];

  logic                       ch_ok;
  logic [ST_W-1:0]            st_idx;
  logic [CFG_DATA_W-1:0]      coef_pair;
  logic signed [SAMPLE_W-1:0] coef;
  logic signed [SAMPLE_W-1:0] x_prev;
  logic signed [SAMPLE_W-1:0] y_prev;
  logic signed [SAMPLE_W-1:0] x_new;
  logic signed [SAMPLE_W-1:0] y_new;
  logic signed [SAMPLE_W-1:0] res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_32;
      for (int i = 0; i < COEF_REGS; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FORMAT: fmt_q     <= cfg_wdata_i[1:0];
        REG_COEF01: coef_q[0] <= cfg_wdata_i;
        REG_COEF23: coef_q[1] <= cfg_wdata_i;
        REG_COEF45: coef_q[2] <= cfg_wdata_i;
        REG_COEF67: coef_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // the input stage moves on whenever the result register is free or drained
  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || !out_valid_q || out_o.ready;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign ch_ok     = {1'b0, s1_q.channel} < NUM_CH;
  assign st_idx    = s1_q.channel[ST_W-1:0];
  assign coef_pair = coef_q[s1_q.channel[2:1]];
  assign coef      = s1_q.channel[0] ? coef_pair[63:32] : coef_pair[31:0];
  assign x_prev    = prev_in_q[st_idx];
  assign y_prev    = prev_out_q[st_idx];

  mdcbf_filter u_filter (
    .fmt_i    (fmt_q),
    .coef_i   (coef),
    .x_prev_i (x_prev),
    .y_prev_i (y_prev),
    .raw_i    (s1_q.sample_in),
    .x_o      (x_new),
    .y_o      (y_new),
    .sample_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q <= in_i.data;
    end
    if (advance) begin
      out_q.channel_out <= s1_q.channel;
      out_q.last_out    <= s1_q.last_frame;
      out_q.sample_out  <= ch_ok ? res : '0;
    end
  end

  // history written as the word leaves the input stage; unknown channels skip
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        prev_in_q[i]  <= '0;
        prev_out_q[i] <= '0;
      end
    end else if (advance && ch_ok) begin
      prev_in_q[st_idx]  <= x_new;
      prev_out_q[st_idx] <= y_new;
    end
  end

  `MDCBF_ASSERT(a_in_lands, (in_i.valid && in_i.ready) |=> s1_valid_q, "accepted word lost")
  `MDCBF_ASSERT(a_s1_holds, (s1_valid_q && !advance) |=> s1_valid_q, "stalled word dropped")
  `MDCBF_ASSERT(a_out_drain, (out_valid_q && out_o.ready && !advance) |=> !out_valid_q, "result repeated")
  `MDCBF_ASSERT(a_fmt16_range, (advance && fmt_q == FMT_16) |=> (out_q.sample_out[31:15] == '0 || out_q.sample_out[31:15] == '1), "16-bit result out of range")

endmodule
